### rtl/mts_pkg.sv
package mts_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;

	// value and stored entry widths; an entry carries two extra bits for 2*v - min
	localparam int VAL_W   = 32;
	localparam int ENTRY_W = VAL_W + 2;

	// minimum after reset
	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7fff_ffff;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic                    func;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] top_value;
		logic signed [VAL_W-1:0] min_value;
		logic                    is_empty;
		logic                    op_error;
	} rsp_t;

endpackage

### rtl/mts_ram.sv
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/min_tracking_stack_core.sv
// min_tracking_stack_core: stack of signed 32-bit values that also reports the
// running minimum, using one minimum register and an encoded entry store.
// Request channel (req_valid / req_stall / req) carries func (push or pop) and
// the value to push. Response channel (rsp_valid / rsp_stall / rsp) returns one
// beat per request: decoded top value, minimum, empty flag and error flag.
// Pop on an empty stack and push on a full stack change nothing and set
// op_error. An empty stack reports top and minimum as zero.
// A push, an error or a pop that empties the stack shows its response in the
// cycle after acceptance; a pop that leaves entries waits in ST_POP_READ for the
// registered read of the entry RAM that refills the cached top entry, and then
// registers its response. Throughput: one push per cycle while rsp_stall stays low;
// a pop with entries left blocks the request channel while in ST_POP_READ.
// The response sits in an output register; a new request is taken while that
// register is being drained, and req_stall rises while a response is held by
// rsp_stall or while a pop waits on its RAM read.
// Reset clears the entry count and sets the minimum to the largest 32-bit value;
// the entry RAM is not cleared, since only entries written by pushes are read.
module min_tracking_stack_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mts_pkg::rsp_t rsp
);

	typedef enum logic {
		ST_READY,
		ST_POP_READ
	} state_t;

	state_t state_q;

	logic [mts_pkg::CNT_W-1:0]                count_q;
	logic signed [mts_pkg::VAL_W-1:0]         min_q;
	logic signed [mts_pkg::ENTRY_W-1:0]       top_q;
	logic                                     rsp_valid_q;
	mts_pkg::rsp_t                            rsp_q;

	logic                                     accept;
	logic                                     rsp_take;
	logic                                     is_push;
	logic                                     is_full;
	logic                                     is_zero;
	logic signed [mts_pkg::ENTRY_W-1:0]       v_ext;
	logic signed [mts_pkg::ENTRY_W-1:0]       min_ext;
	logic signed [mts_pkg::ENTRY_W-1:0]       enc_entry;
	logic signed [mts_pkg::ENTRY_W-1:0]       restore_full;
	logic                                     push_le_min;
	logic                                     top_below_min;
	logic signed [mts_pkg::VAL_W-1:0]         pop_min;
	logic                                     ram_we;
	logic                                     ram_re;
	logic [mts_pkg::ADDR_W-1:0]               ram_waddr;
	logic [mts_pkg::ADDR_W-1:0]               ram_raddr;
	logic [mts_pkg::ENTRY_W-1:0]              ram_wdata;
	logic [mts_pkg::ENTRY_W-1:0]              ram_rdata;
	logic [mts_pkg::CNT_W-1:0]                count_m2;

	// an entry below the minimum stands for the minimum itself
	function automatic logic signed [mts_pkg::VAL_W-1:0] decode_top(
		input logic signed [mts_pkg::ENTRY_W-1:0] e,
		input logic signed [mts_pkg::VAL_W-1:0]   m
	);
		logic signed [mts_pkg::ENTRY_W-1:0] m_ext;
		m_ext = {{(mts_pkg::ENTRY_W - mts_pkg::VAL_W){m[mts_pkg::VAL_W-1]}}, m};
		if (e < m_ext) begin
			return m;
		end
		return e[mts_pkg::VAL_W-1:0];
	endfunction

	// handshake
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign req_stall = (state_q != ST_READY) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// operation decode
	assign is_push = (req.func == mts_pkg::FUNC_PUSH);
	assign is_full = (count_q == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
	assign is_zero = (count_q == '0);

	// entry encoding and minimum restore
	always_comb begin
		v_ext = {{(mts_pkg::ENTRY_W - mts_pkg::VAL_W){req.value[mts_pkg::VAL_W-1]}},
			req.value};
		min_ext = {{(mts_pkg::ENTRY_W - mts_pkg::VAL_W){min_q[mts_pkg::VAL_W-1]}}, min_q};
		enc_entry     = (v_ext <<< 1) - min_ext;
		restore_full  = (min_ext <<< 1) - top_q;
		push_le_min   = (req.value <= min_q);
		top_below_min = (top_q < min_ext);
		pop_min       = top_below_min ? restore_full[mts_pkg::VAL_W-1:0] : min_q;
	end

	// memory access: push writes at count, pop refetches the entry under the top
	assign count_m2  = count_q - mts_pkg::CNT_W'(2);
	assign ram_we    = accept && is_push && !is_full;
	assign ram_waddr = count_q[mts_pkg::ADDR_W-1:0];
	assign ram_wdata = (is_zero || !push_le_min) ? v_ext : enc_entry;
	assign ram_re    = accept && !is_push && (count_q > mts_pkg::CNT_W'(1));
	assign ram_raddr = count_m2[mts_pkg::ADDR_W-1:0];

	mts_ram #(
		.WIDTH(mts_pkg::ENTRY_W),
		.DEPTH(mts_pkg::STACK_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer, stack state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			count_q     <= '0;
			min_q       <= mts_pkg::INT_MAX;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_READY: begin
					if (accept) begin
						if (is_push) begin
							rsp_valid_q <= 1'b1;
							if (is_full) begin
								// full: report unchanged top and minimum
								rsp_q.top_value <= decode_top(top_q, min_q);
								rsp_q.min_value <= min_q;
								rsp_q.is_empty  <= 1'b0;
								rsp_q.op_error  <= 1'b1;
							end else begin
								count_q         <= count_q + mts_pkg::CNT_W'(1);
								top_q           <= ram_wdata;
								rsp_q.top_value <= req.value;
								rsp_q.is_empty  <= 1'b0;
								rsp_q.op_error  <= 1'b0;
								if (is_zero || push_le_min) begin
									min_q           <= req.value;
									rsp_q.min_value <= req.value;
								end else begin
									rsp_q.min_value <= min_q;
								end
							end
						end else begin
							if (is_zero) begin
								// pop on empty
								rsp_valid_q     <= 1'b1;
								rsp_q.top_value <= '0;
								rsp_q.min_value <= '0;
								rsp_q.is_empty  <= 1'b1;
								rsp_q.op_error  <= 1'b1;
							end else begin
								count_q <= count_q - mts_pkg::CNT_W'(1);
								min_q   <= pop_min;
								if (count_q == mts_pkg::CNT_W'(1)) begin
									rsp_valid_q     <= 1'b1;
									rsp_q.top_value <= '0;
									rsp_q.min_value <= '0;
									rsp_q.is_empty  <= 1'b1;
									rsp_q.op_error  <= 1'b0;
								end else begin
									state_q <= ST_POP_READ;
								end
							end
						end
					end
				end
				ST_POP_READ: begin
					// new top arrives from the RAM
					top_q           <= ram_rdata;
					rsp_valid_q     <= 1'b1;
					rsp_q.top_value <= decode_top(ram_rdata, min_q);
					rsp_q.min_value <= min_q;
					rsp_q.is_empty  <= 1'b0;
					rsp_q.op_error  <= 1'b0;
					state_q         <= ST_READY;
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// count never runs past the stack depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH))
		else $error("entry count above stack depth");

	// every accepted beat yields a response now or after the pop read
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp_valid_q || state_q == ST_POP_READ))
		else $error("accepted beat produced no response");

	// the pop read state is left in the next cycle and delivers a response
	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_READ |=> (state_q == ST_READY && rsp_valid_q))
		else $error("pop read did not complete");

	// an empty response reports zero top and minimum
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.is_empty) |-> (rsp_q.top_value == '0 && rsp_q.min_value == '0))
		else $error("empty response with nonzero fields");
`endif

endmodule
